@@ hdl/hpr_pkg.sv @@
// ----------------------------------------------------------------------------
// hpr_pkg: shared types, constants and hash round functions
// 16-byte key hash: seed state, mix and final rounds, queue status.
// ----------------------------------------------------------------------------
`default_nettype none
package hpr_pkg;

   localparam logic [31:0] HASH_GOLDEN     = 32'h9e37_79b9;
   localparam logic [31:0] HASH_INIT_EXTRA = 32'd3923095;
   localparam logic [31:0] KEY_BYTES       = 32'd16;
   localparam logic [63:0] PART_SEED       = 64'h7A5B_2236_7996_DCFD;
   localparam logic [63:0] PART_COMBINE    = 64'h49a0_f4dd_15e5_a8e3;

   localparam int MIX_STEPS   = 6;
   localparam int FINAL_STEPS = 7;
   localparam int HASH_STEPS  = MIX_STEPS + FINAL_STEPS;
   localparam int HASH_WIDTH  = 64;
   localparam int PART_WIDTH  = 32;
   localparam int QUEUE_DEPTH = 32;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } hpr_abc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } hpr_qstat_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      rotl32 = (x << r) | (x >> (32 - r));
   endfunction

   function automatic hpr_abc_type mix_step(input int idx, input hpr_abc_type s);
      hpr_abc_type o;
      o = s;
      case (idx)
         0: begin o.a = (s.a - s.c) ^ rotl32(s.c, 4);  o.c = s.c + s.b; end
         1: begin o.b = (s.b - s.a) ^ rotl32(s.a, 6);  o.a = s.a + s.c; end
         2: begin o.c = (s.c - s.b) ^ rotl32(s.b, 8);  o.b = s.b + s.a; end
         3: begin o.a = (s.a - s.c) ^ rotl32(s.c, 16); o.c = s.c + s.b; end
         4: begin o.b = (s.b - s.a) ^ rotl32(s.a, 19); o.a = s.a + s.c; end
         default: begin o.c = (s.c - s.b) ^ rotl32(s.b, 4); o.b = s.b + s.a; end
      endcase
      return o;
   endfunction

   function automatic hpr_abc_type final_step(input int idx, input hpr_abc_type s);
      hpr_abc_type o;
      o = s;
      case (idx)
         0: o.c = (s.c ^ s.b) - rotl32(s.b, 14);
         1: o.a = (s.a ^ s.c) - rotl32(s.c, 11);
         2: o.b = (s.b ^ s.a) - rotl32(s.a, 25);
         3: o.c = (s.c ^ s.b) - rotl32(s.b, 16);
         4: o.a = (s.a ^ s.c) - rotl32(s.c, 4);
         5: o.b = (s.b ^ s.a) - rotl32(s.a, 14);
         default: o.c = (s.c ^ s.b) - rotl32(s.b, 24);
      endcase
      return o;
   endfunction

   function automatic hpr_abc_type seed_state();
      hpr_abc_type s;
      logic [31:0] init;
      init = HASH_GOLDEN + KEY_BYTES + HASH_INIT_EXTRA;
      s.a  = init + PART_SEED[63:32];
      s.b  = init + PART_SEED[31:0];
      s.c  = init;
      for (int i = 0; i < MIX_STEPS; i++) s = mix_step(i, s);
      return s;
   endfunction

endpackage
`default_nettype wire

@@ hdl/hpr_hash_front.sv @@
// ----------------------------------------------------------------------------
// hpr_hash_front: hash pipeline
// Free-running pipeline, one mix or final round a stage, then combine add.
// ----------------------------------------------------------------------------
`default_nettype none
module hpr_hash_front import hpr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [127:0]          in_key,
   input  wire logic                  in_last,
   output logic                       out_valid,
   output logic [HASH_WIDTH-1:0]      out_hash,
   output logic                       out_last
);

   localparam hpr_abc_type SEED_ABC = seed_state();

   logic        valid_ff [HASH_STEPS+1];
   logic        valid_in [HASH_STEPS+1];
   hpr_abc_type abc_ff   [HASH_STEPS+1];
   hpr_abc_type abc_in   [HASH_STEPS+1];
   logic [31:0] tail_ff  [HASH_STEPS+1];
   logic        last_ff  [HASH_STEPS+1];
   logic        out_valid_ff;
   logic [HASH_WIDTH-1:0] out_hash_ff;
   logic        out_last_ff;

   always_comb begin
      valid_in[0] = in_valid;
      abc_in[0].a = SEED_ABC.a + in_key[31:0];
      abc_in[0].b = SEED_ABC.b + in_key[63:32];
      abc_in[0].c = SEED_ABC.c + in_key[95:64];
      for (int k = 1; k <= HASH_STEPS; k++) begin
         valid_in[k] = valid_ff[k-1];
         if (k <= MIX_STEPS) begin
            abc_in[k] = mix_step(k - 1, abc_ff[k-1]);
         end else if (k == MIX_STEPS + 1) begin
            abc_in[k] = final_step(0, '{a: abc_ff[k-1].a + tail_ff[k-1],
                                        b: abc_ff[k-1].b, c: abc_ff[k-1].c});
         end else begin
            abc_in[k] = final_step(k - 1 - MIX_STEPS, abc_ff[k-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= HASH_STEPS; k++) valid_ff[k] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k <= HASH_STEPS; k++) valid_ff[k] <= valid_in[k];
         out_valid_ff <= valid_ff[HASH_STEPS];
      end
      abc_ff[0]  <= abc_in[0];
      tail_ff[0] <= in_key[127:96];
      last_ff[0] <= in_last;
      for (int k = 1; k <= HASH_STEPS; k++) begin
         abc_ff[k]  <= abc_in[k];
         tail_ff[k] <= tail_ff[k-1];
         last_ff[k] <= last_ff[k-1];
      end
      out_hash_ff <= {abc_ff[HASH_STEPS].b, abc_ff[HASH_STEPS].c} + PART_COMBINE;
      out_last_ff <= last_ff[HASH_STEPS];
   end

   assign out_valid = out_valid_ff;
   assign out_hash  = out_hash_ff;
   assign out_last  = out_last_ff;

endmodule
`default_nettype wire

@@ hdl/hpr_queue.sv @@
// ----------------------------------------------------------------------------
// hpr_queue: hash queue
// Small FIFO between hash pipeline and modulo pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module hpr_queue import hpr_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH,
   parameter int WIDTH = HASH_WIDTH + 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output hpr_qstat_type         status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      if (pop)  head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) entry_ff[tail_ff] <= push_data;
   end

   assign pop_data     = entry_ff[head_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

endmodule
`default_nettype wire

@@ hdl/hpr_mod_back.sv @@
// ----------------------------------------------------------------------------
// hpr_mod_back: modulo pipeline
// Restoring remainder, one dividend bit a stage; last stage is the output.
// ----------------------------------------------------------------------------
`default_nettype none
module hpr_mod_back import hpr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire logic [HASH_WIDTH-1:0] in_hash,
   input  wire logic                  in_last,
   input  wire logic [PART_WIDTH-1:0] modulus,
   output logic                       out_valid,
   output logic [PART_WIDTH-1:0]      out_rem,
   output logic                       out_last
);

   logic                  valid_ff [HASH_WIDTH];
   logic [PART_WIDTH-1:0] rem_ff   [HASH_WIDTH];
   logic [PART_WIDTH-1:0] rem_in   [HASH_WIDTH];
   logic [HASH_WIDTH-1:0] div_ff   [HASH_WIDTH];
   logic                  last_ff  [HASH_WIDTH];
   logic [PART_WIDTH:0]   trial    [HASH_WIDTH];

   always_comb begin
      for (int k = 0; k < HASH_WIDTH; k++) begin
         if (k == 0) trial[k] = {{PART_WIDTH{1'b0}}, in_hash[HASH_WIDTH-1]};
         else        trial[k] = {rem_ff[k-1], div_ff[k-1][HASH_WIDTH-1]};
         if (trial[k] >= {1'b0, modulus})
            rem_in[k] = PART_WIDTH'(trial[k] - {1'b0, modulus});
         else
            rem_in[k] = trial[k][PART_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HASH_WIDTH; k++) valid_ff[k] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < HASH_WIDTH; k++) valid_ff[k] <= valid_ff[k-1];
      end
      if (advance) begin
         rem_ff[0]  <= rem_in[0];
         div_ff[0]  <= in_hash << 1;
         last_ff[0] <= in_last;
         for (int k = 1; k < HASH_WIDTH; k++) begin
            rem_ff[k]  <= rem_in[k];
            div_ff[k]  <= div_ff[k-1] << 1;
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[HASH_WIDTH-1];
   assign out_rem   = rem_ff[HASH_WIDTH-1];
   assign out_last  = last_ff[HASH_WIDTH-1];

endmodule
`default_nettype wire

@@ hdl/hash_partition_router_16byte.sv @@
// ----------------------------------------------------------------------------
// hash_partition_router_16byte: 16-byte key hash partition router
// Hashes each key, adds the combine constant, reduces modulo partition count.
//
//  Channel | Direction | Handshake          | Payload
//  req     | in        | req_tvalid/tready  | tdata key_low, key_high; tlast last_key
//  rsp     | out       | rsp_tvalid/tready  | tdata partition_index; tlast last_result
//  csr     | in        | csr_valid/ready    | csr_data partition_count
//
//  One key a cycle sustained while rsp is not stalled; the hash pipeline and queue
//  feed the modulo pipeline, one remainder bit a stage.
//  The hash pipeline runs freely; credits against the queue depth set req_tready.
//  A stalled rsp halts only the modulo pipeline; the queue absorbs keys in flight.
//  Synchronous reset clears all valid bits; partition count resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none
module hash_partition_router_16byte import hpr_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [127:0] req_tdata,   // key_low [63:0], key_high [127:64]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // partition_index [31:0]
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data      // partition_count [31:0]
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [31:0]           part_ff, part_in;
   logic [CNT_W-1:0]      credit_ff, credit_in;
   logic                  accept, advance, pop;
   logic                  hv;
   logic [HASH_WIDTH-1:0] hh;
   logic                  hl;
   logic [HASH_WIDTH:0]   qdata;
   hpr_qstat_type         qstat;

   assign csr_ready  = 1'b1;
   assign req_tready = (credit_ff < CNT_W'(DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign pop        = advance && !qstat.empty;

   always_comb begin
      part_in   = part_ff;
      credit_in = credit_ff;
      if (csr_valid) part_in = (csr_data == 32'd0) ? 32'd1 : csr_data;
      if (accept && !pop) credit_in = credit_ff + 1'b1;
      if (pop && !accept) credit_in = credit_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff   <= 32'd1;
         credit_ff <= '0;
      end else begin
         part_ff   <= part_in;
         credit_ff <= credit_in;
      end
   end

   hpr_hash_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(accept), .in_key(req_tdata), .in_last(req_tlast),
      .out_valid(hv), .out_hash(hh), .out_last(hl)
   );

   hpr_queue #(.DEPTH(DEPTH), .WIDTH(HASH_WIDTH + 1)) u_queue (
      .clock(clock), .reset(reset),
      .push(hv), .push_data({hl, hh}),
      .pop(pop), .pop_data(qdata), .status(qstat)
   );

   hpr_mod_back u_back (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(pop), .in_hash(qdata[HASH_WIDTH-1:0]), .in_last(qdata[HASH_WIDTH]),
      .modulus(part_ff),
      .out_valid(rsp_tvalid), .out_rem(rsp_tdata), .out_last(rsp_tlast)
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CNT_W'(DEPTH)) else $error("credit count overflow");
   a_part_nonzero: assert property (@(posedge clock) disable iff (reset)
      part_ff != 32'd0) else $error("partition count zero");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(hv && qstat.full && !pop)) else $error("push into full queue");
   a_pop_credit: assert property (@(posedge clock) disable iff (reset)
      !qstat.empty |-> credit_ff != '0) else $error("queue holds uncredited entry");

endmodule
`default_nettype wire

@@ verif/tb_hash_partition_router_16byte.sv @@
// ----------------------------------------------------------------------------
// tb_hash_partition_router_16byte: partition router testbench
// Drives keys, checks partition_index and last flag against an in-bench hash
// predictor, over several partition counts and random bus idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_hash_partition_router_16byte import hpr_pkg::*;;

   typedef struct packed {
      logic [31:0] part;
      logic        last;
   } route_type;

   localparam int LATENCY     = 100;
   localparam int CYCLE_LIMIT = 600000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [31:0]  csr_data = '0;

   route_type    routes_due[$];
   logic [31:0]  part_count = 32'd1;
   int           errors = 0;
   int           cycles = 0;
   bit           idle_rx = 1'b1;
   bit           idle_tx = 1'b1;
   bit           hold_rx = 1'b0;

   hash_partition_router_16byte dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] rot(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic void churn(inout logic [31:0] a, b, c);
      a -= c; a ^= rot(c, 4);  c += b;
      b -= a; b ^= rot(a, 6);  a += c;
      c -= b; c ^= rot(b, 8);  b += a;
      a -= c; a ^= rot(c, 16); c += b;
      b -= a; b ^= rot(a, 19); a += c;
      c -= b; c ^= rot(b, 4);  b += a;
   endfunction

   function automatic logic [31:0] route_key(input logic [63:0] lo, hi,
                                            input logic [31:0] count);
      logic [31:0] a, b, c;
      logic [63:0] sum;
      a = HASH_GOLDEN + KEY_BYTES + HASH_INIT_EXTRA;
      b = a;
      c = a;
      a += PART_SEED[63:32];
      b += PART_SEED[31:0];
      churn(a, b, c);
      a += lo[31:0];
      b += lo[63:32];
      c += hi[31:0];
      churn(a, b, c);
      a += hi[63:32];
      c ^= b; c -= rot(b, 14);
      a ^= c; a -= rot(c, 11);
      b ^= a; b -= rot(a, 25);
      c ^= b; c -= rot(b, 16);
      a ^= c; a -= rot(c, 4);
      b ^= a; b -= rot(a, 14);
      c ^= b; c -= rot(b, 24);
      sum = {b, c} + PART_COMBINE;
      return 32'(sum % {32'd0, count});
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls unless idling is off, long hold on request
   always @(posedge clock) begin
      route_type want;
      int        gap;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (routes_due.size() == 0) begin
            $display("%0t unexpected transaction: actual %h/%b", $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = routes_due.pop_front();
            if (rsp_tdata !== want.part || rsp_tlast !== want.last) begin
               $display("%0t mismatch: expected %h/%b actual %h/%b", $time,
                        want.part, want.last, rsp_tdata, rsp_tlast);
               errors++;
            end
         end
      end
      if (hold_rx) rsp_tready <= 1'b0;
      else if (idle_rx && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 9);
         rsp_tready <= 1'b0;
         repeat (gap) @(posedge clock);
         rsp_tready <= 1'b1;
      end else rsp_tready <= 1'b1;
   end

   task automatic send_key(input logic [63:0] lo, hi, input logic last);
      route_type r;
      if (idle_tx && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {hi, lo};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      r.part = route_key(lo, hi, part_count);
      r.last = last;
      routes_due.push_back(r);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (routes_due.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_count(input logic [31:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      part_count = (v == 0) ? 32'd1 : v;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      send_key('0, '0, 1'b0);
      send_key('1, '1, 1'b1);
      send_key('1, '0, 1'b0);
      send_key('0, '1, 1'b1);
      send_key(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_key(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000, 1'b1);
   endtask

   task automatic test_zero_count();
      write_count(32'd0);
      repeat (6) send_key(rand64(), rand64(), $urandom_range(0, 1));
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) send_key(rand64(), rand64(), $urandom_range(0, 1));
   endtask

   task automatic test_backpressure();
      drain();
      fork
         begin
            hold_rx = 1'b1;
            repeat (200) @(posedge clock);
            hold_rx = 1'b0;
         end
         test_random(160);
      join
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_zero_count();
      write_count(32'hFFFF_FFFF);
      test_directed();
      test_random(300);
      write_count(32'd2);
      test_random(250);
      write_count(32'd7);
      test_random(250);
      test_backpressure();
      write_count(32'h8000_0000);
      test_random(300);
      write_count($urandom | 32'h1);
      test_random(300);
      write_count(32'd1000);
      idle_rx = 1'b0;
      idle_tx = 1'b0;
      test_random(300);
      drain();
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
hdl/hpr_pkg.sv
hdl/hpr_hash_front.sv
hdl/hpr_queue.sv
hdl/hpr_mod_back.sv
hdl/hash_partition_router_16byte.sv
verif/tb_hash_partition_router_16byte.sv
